/* src/wfc_pkg.sv */
`default_nettype none

package wfc_pkg;

    localparam int CHAR_W   = 8;
    localparam int LETTER_W = 5;
    localparam int INDEX_W  = 8;
    localparam int COUNT_W  = 32;

    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef logic [LETTER_W-1:0] letter_t;
    typedef logic [COUNT_W-1:0]  count_t;

    typedef enum logic
    {
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef struct packed
    {
        logic rd_en;
        logic wr_word;
        logic wr_count;
    } tbl_ctrl_t;

endpackage

`default_nettype wire

/* src/wfc_char_if.sv */
`default_nettype none

interface wfc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

`default_nettype wire

/* src/wfc_result_if.sv */
`default_nettype none

interface wfc_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  entry_index;
    logic [31:0] word_count;
    logic        is_new;
    logic        table_full;
    logic        word_truncated;

    modport source (output valid, output entry_index, output word_count, output is_new,
                    output table_full, output word_truncated, input ready);
    modport sink   (input valid, input entry_index, input word_count, input is_new,
                    input table_full, input word_truncated, output ready);
endinterface

`default_nettype wire

/* src/word_frequency_counter_unit.sv */
// Counts words in a byte stream. Letters are folded to lower case and collected, up to
// MAX_WORD_LEN per word (extra letters are dropped and flagged); any other byte closes an
// open word and produces one result beat with the table slot and the updated count, a new
// entry with count 1, or a table-full drop. No new byte is taken while a word end is
// handled: the single read port of the word table walks the stored rows (at most
// TABLE_ENTRIES) one per cycle, with a full-word compare on each, and the input also
// waits while the previous result still waits unaccepted. The table is empty after
// reset, with no clearing pass; a result waits in an output register while letters of
// the next word are taken.
`default_nettype none

module word_frequency_counter_unit
    import wfc_pkg::*;
#(
    parameter int MAX_WORD_LEN  = 20,
    parameter int TABLE_ENTRIES = 256
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    wfc_char_if.sink   char_in,
    wfc_result_if.source result_out
);

    localparam int LEN_W   = $clog2(MAX_WORD_LEN + 1);
    localparam int SLOT_W  = $clog2(TABLE_ENTRIES);
    localparam int SLOT_CW = $clog2(TABLE_ENTRIES + 1);
    localparam int ROW_W   = MAX_WORD_LEN * LETTER_W;

    state_t              state_reg,     state_next;
    logic [SLOT_CW-1:0]  scan_reg,      scan_next;
    logic                chk_valid_reg, chk_valid_next;
    logic [SLOT_W-1:0]   chk_slot_reg,  chk_slot_next;
    logic [SLOT_CW-1:0]  used_reg,      used_next;

    logic                out_valid_reg;
    logic [INDEX_W-1:0]  index_reg,     index_next;
    count_t              count_reg,     count_next;
    logic                new_reg,       new_next;
    logic                full_reg,      full_next;
    logic                trunc_reg;

    logic                is_letter;
    letter_t             letter;
    logic                push;
    logic                clear;
    logic                load;
    logic                out_free;
    logic                hit;
    logic                more;

    logic [ROW_W-1:0]    wb_letters;
    logic [LEN_W-1:0]    wb_len;
    logic                wb_overflow;
    logic                wb_in_word;

    tbl_ctrl_t           tctl;
    logic [SLOT_W-1:0]   wr_addr;
    count_t              wr_count;
    logic [ROW_W-1:0]    rd_letters;
    logic [LEN_W-1:0]    rd_len;
    count_t              rd_count;
    logic                row_hit;

    always_comb
    begin
        is_letter = 1'b0;
        letter    = '0;
        if (char_in.char_code inside {[CHAR_UPPER_A:CHAR_UPPER_Z]})
        begin
            is_letter = 1'b1;
            letter    = LETTER_W'(char_in.char_code - CHAR_UPPER_A);
        end
        else if (char_in.char_code inside {[CHAR_LOWER_A:CHAR_LOWER_Z]})
        begin
            is_letter = 1'b1;
            letter    = LETTER_W'(char_in.char_code - CHAR_LOWER_A);
        end
    end

    wfc_word_buf #(
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_word_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .clear    (clear),
        .letter   (letter),
        .letters  (wb_letters),
        .len      (wb_len),
        .overflow (wb_overflow),
        .in_word  (wb_in_word)
    );

    wfc_table #(
        .MAX_WORD_LEN  (MAX_WORD_LEN),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .clk        (clk),
        .ctrl       (tctl),
        .rd_addr    (scan_reg[SLOT_W-1:0]),
        .wr_addr    (wr_addr),
        .wr_letters (wb_letters),
        .wr_len     (wb_len),
        .wr_count   (wr_count),
        .rd_letters (rd_letters),
        .rd_len     (rd_len),
        .rd_count   (rd_count)
    );

    wfc_match #(
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_match (
        .word_letters (wb_letters),
        .word_len     (wb_len),
        .row_letters  (rd_letters),
        .row_len      (rd_len),
        .hit          (row_hit)
    );

    assign out_free = !out_valid_reg || result_out.ready;
    assign hit      = chk_valid_reg && row_hit;
    assign more     = (scan_reg < used_reg);

    always_comb
    begin
        state_next     = state_reg;
        scan_next      = scan_reg;
        chk_valid_next = chk_valid_reg;
        chk_slot_next  = chk_slot_reg;
        used_next      = used_reg;
        tctl           = '0;
        wr_addr        = chk_slot_reg;
        wr_count       = (rd_count == COUNT_MAX) ? rd_count : rd_count + COUNT_W'(1);
        push           = 1'b0;
        clear          = 1'b0;
        load           = 1'b0;
        index_next     = INDEX_W'(chk_slot_reg);
        count_next     = wr_count;
        new_next       = 1'b0;
        full_next      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (char_in.valid)
                begin
                    if (is_letter)
                    begin
                        push = 1'b1;
                    end
                    else if (wb_in_word)
                    begin
                        state_next     = ST_SCAN;
                        scan_next      = '0;
                        chk_valid_next = 1'b0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    if (out_free)
                    begin
                        tctl.wr_count  = 1'b1;
                        load           = 1'b1;
                        clear          = 1'b1;
                        chk_valid_next = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
                else if (more)
                begin
                    tctl.rd_en     = 1'b1;
                    chk_valid_next = 1'b1;
                    chk_slot_next  = scan_reg[SLOT_W-1:0];
                    scan_next      = scan_reg + SLOT_CW'(1);
                end
                else if (out_free)
                begin
                    load           = 1'b1;
                    clear          = 1'b1;
                    chk_valid_next = 1'b0;
                    state_next     = ST_IDLE;
                    if (used_reg < SLOT_CW'(TABLE_ENTRIES))
                    begin
                        wr_addr       = used_reg[SLOT_W-1:0];
                        wr_count      = COUNT_W'(1);
                        tctl.wr_word  = 1'b1;
                        tctl.wr_count = 1'b1;
                        used_next     = used_reg + SLOT_CW'(1);
                        index_next    = INDEX_W'(used_reg[SLOT_W-1:0]);
                        count_next    = COUNT_W'(1);
                        new_next      = 1'b1;
                    end
                    else
                    begin
                        index_next = '0;
                        count_next = '0;
                        full_next  = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_reg      <= '0;
            chk_valid_reg <= 1'b0;
            chk_slot_reg  <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            chk_valid_reg <= chk_valid_next;
            chk_slot_reg  <= chk_slot_next;
            used_reg      <= used_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            index_reg <= index_next;
            count_reg <= count_next;
            new_reg   <= new_next;
            full_reg  <= full_next;
            trunc_reg <= wb_overflow;
        end
    end

    assign char_in.ready             = (state_reg == ST_IDLE);
    assign result_out.valid          = out_valid_reg;
    assign result_out.entry_index    = index_reg;
    assign result_out.word_count     = count_reg;
    assign result_out.is_new         = new_reg;
    assign result_out.table_full     = full_reg;
    assign result_out.word_truncated = trunc_reg;

endmodule

`default_nettype wire

/* src/wfc_word_buf.sv */
`default_nettype none

module wfc_word_buf
    import wfc_pkg::*;
#(
    parameter int MAX_WORD_LEN = 20,
    parameter int LEN_W        = $clog2(MAX_WORD_LEN + 1)
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             push,
    input  wire logic                             clear,
    input  wire letter_t                          letter,
    output      logic [MAX_WORD_LEN*LETTER_W-1:0] letters,
    output      logic [LEN_W-1:0]                 len,
    output      logic                             overflow,
    output      logic                             in_word
);

    letter_t          letters_reg [MAX_WORD_LEN];
    logic [LEN_W-1:0] len_reg;
    logic             ovf_reg;
    logic             in_word_reg;
    logic             full;

    assign full = (len_reg == LEN_W'(MAX_WORD_LEN));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= '0;
            ovf_reg     <= 1'b0;
            in_word_reg <= 1'b0;
        end
        else if (clear)
        begin
            len_reg     <= '0;
            ovf_reg     <= 1'b0;
            in_word_reg <= 1'b0;
        end
        else if (push)
        begin
            in_word_reg <= 1'b1;
            if (full)
            begin
                ovf_reg <= 1'b1;
            end
            else
            begin
                len_reg <= len_reg + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_WORD_LEN; i++)
        begin
            if (push && !full && (len_reg == LEN_W'(i)))
            begin
                letters_reg[i] <= letter;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_WORD_LEN; i++)
        begin
            letters[i*LETTER_W +: LETTER_W] = letters_reg[i];
        end
    end

    assign len      = len_reg;
    assign overflow = ovf_reg;
    assign in_word  = in_word_reg;

endmodule

`default_nettype wire

/* src/wfc_table.sv */
`default_nettype none

module wfc_table
    import wfc_pkg::*;
#(
    parameter int MAX_WORD_LEN  = 20,
    parameter int TABLE_ENTRIES = 256,
    parameter int LEN_W         = $clog2(MAX_WORD_LEN + 1),
    parameter int SLOT_W        = $clog2(TABLE_ENTRIES)
)
(
    input  wire logic                             clk,
    input  wire tbl_ctrl_t                        ctrl,
    input  wire logic [SLOT_W-1:0]                rd_addr,
    input  wire logic [SLOT_W-1:0]                wr_addr,
    input  wire logic [MAX_WORD_LEN*LETTER_W-1:0] wr_letters,
    input  wire logic [LEN_W-1:0]                 wr_len,
    input  wire count_t                           wr_count,
    output      logic [MAX_WORD_LEN*LETTER_W-1:0] rd_letters,
    output      logic [LEN_W-1:0]                 rd_len,
    output      count_t                           rd_count
);

    logic [MAX_WORD_LEN*LETTER_W-1:0] letters_mem [TABLE_ENTRIES];
    logic [LEN_W-1:0]                 len_mem     [TABLE_ENTRIES];
    count_t                           count_mem   [TABLE_ENTRIES];

    logic [MAX_WORD_LEN*LETTER_W-1:0] rd_letters_reg;
    logic [LEN_W-1:0]                 rd_len_reg;
    count_t                           rd_count_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_word)
        begin
            letters_mem[wr_addr] <= wr_letters;
            len_mem[wr_addr]     <= wr_len;
        end
        if (ctrl.rd_en)
        begin
            rd_letters_reg <= letters_mem[rd_addr];
            rd_len_reg     <= len_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_count)
        begin
            count_mem[wr_addr] <= wr_count;
        end
        if (ctrl.rd_en)
        begin
            rd_count_reg <= count_mem[rd_addr];
        end
    end

    assign rd_letters = rd_letters_reg;
    assign rd_len     = rd_len_reg;
    assign rd_count   = rd_count_reg;

endmodule

`default_nettype wire

/* src/wfc_match.sv */
`default_nettype none

module wfc_match
    import wfc_pkg::*;
#(
    parameter int MAX_WORD_LEN = 20,
    parameter int LEN_W        = $clog2(MAX_WORD_LEN + 1)
)
(
    input  wire logic [MAX_WORD_LEN*LETTER_W-1:0] word_letters,
    input  wire logic [LEN_W-1:0]                 word_len,
    input  wire logic [MAX_WORD_LEN*LETTER_W-1:0] row_letters,
    input  wire logic [LEN_W-1:0]                 row_len,
    output      logic                             hit
);

    logic [MAX_WORD_LEN-1:0] eq;

    // letters past the word end are stale and ignored
    always_comb
    begin
        for (int k = 0; k < MAX_WORD_LEN; k++)
        begin
            eq[k] = (LEN_W'(k) >= word_len) ||
                    (word_letters[k*LETTER_W +: LETTER_W] ==
                     row_letters[k*LETTER_W +: LETTER_W]);
        end
    end

    assign hit = (row_len == word_len) && (&eq);

endmodule

`default_nettype wire

/* src/wfc_checker.sv */
`default_nettype none

module wfc_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [7:0]  entry_index,
    input wire logic [31:0] word_count,
    input wire logic        is_new,
    input wire logic        table_full
);

    // a stalled result beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(word_count) && $stable(entry_index))
        else $error("result beat changed while stalled");

    a_new_or_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(is_new && table_full))
        else $error("result both new and dropped");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && table_full |-> (word_count == 32'd0) && (entry_index == 8'd0))
        else $error("dropped word reports slot or count");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !table_full |-> (word_count != 32'd0))
        else $error("counted word reports zero");

    a_new_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_new |-> (word_count == 32'd1))
        else $error("new entry count not one");

endmodule

bind word_frequency_counter_unit wfc_checker u_wfc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (result_out.valid),
    .out_ready   (result_out.ready),
    .entry_index (result_out.entry_index),
    .word_count  (result_out.word_count),
    .is_new      (result_out.is_new),
    .table_full  (result_out.table_full)
);

`default_nettype wire
